/* hdl/hec_pkg.sv */
// ----------------------------------------------------------------------------
// Hamming even parity codec package
// Shared widths, operation codes, status codes and the result word type.
// ----------------------------------------------------------------------------
package hec_pkg;

   localparam int WORD_W = 64;
   localparam int SYN_W  = 6;
   localparam int LEN_W  = 6;
   localparam int CLEN_W = 7;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CORRECTED = 2'd1;
   localparam logic [1:0] STATUS_BEYOND    = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [SYN_W-1:0]  syndrome;
      logic [1:0]        status;
   } result_type;

endpackage

/* hdl/hec_core.sv */
// ----------------------------------------------------------------------------
// Hamming codec datapath
// Encodes data bits into a codeword or checks and corrects a received
// codeword, all in one pass of XOR trees.
// ----------------------------------------------------------------------------
module hec_core (
   input  logic                             operation,
   input  logic [hec_pkg::WORD_W-1:0]       payload,
   input  logic [hec_pkg::CLEN_W-1:0]       code_len,
   output hec_pkg::result_type              result
);

   always_comb begin
      logic [hec_pkg::WORD_W-1:0] mask;
      logic [hec_pkg::WORD_W-1:0] spread;
      logic [hec_pkg::WORD_W-1:0] word;
      logic [hec_pkg::SYN_W-1:0]  syn;
      int unsigned                d;

      mask   = (64'd1 << code_len) - 64'd1;
      spread = '0;
      d      = 0;
      // Data bits fill the positions that are not powers of two, in order.
      for (int pos = 1; pos <= hec_pkg::WORD_W; pos++) begin
         if ((pos & (pos - 1)) != 0) begin
            spread[6'(pos - 1)] = payload[6'(d)];
            d = d + 1;
         end
      end

      if (operation == hec_pkg::OP_DECODE) begin
         word = payload & mask;
      end else begin
         word = spread & mask;
      end

      // Each syndrome bit covers the positions that have that bit set.
      syn = '0;
      for (int pos = 1; pos < hec_pkg::WORD_W; pos++) begin
         for (int b = 0; b < hec_pkg::SYN_W; b++) begin
            if (((pos >> b) & 1) != 0) begin
               syn[b] = syn[b] ^ word[6'(pos - 1)];
            end
         end
      end

      result.word     = word;
      result.syndrome = '0;
      result.status   = hec_pkg::STATUS_OK;
      if (operation == hec_pkg::OP_ENCODE) begin
         // Parity positions are still zero, so the check value is the parity bit.
         for (int b = 0; b < hec_pkg::SYN_W; b++) begin
            result.word[6'((1 << b) - 1)] = syn[b];
         end
      end else begin
         result.syndrome = syn;
         if (syn != '0) begin
            if ({1'b0, syn} <= code_len) begin
               result.word   = word ^ (64'd1 << (syn - 6'd1));
               result.status = hec_pkg::STATUS_CORRECTED;
            end else begin
               result.status = hec_pkg::STATUS_BEYOND;
            end
         end
      end
   end

endmodule

/* hdl/hamming_even_parity_codec.sv */
// ----------------------------------------------------------------------------
// Hamming even parity codec
// Single error correcting encoder and decoder with a programmable data length.
// ----------------------------------------------------------------------------
// An accepted request word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; the input register and the result register
// form a two stage pipeline that keeps moving while the response side takes.
// Reset: synchronous; clears both stage valid flags and sets the data length
// to 4 bits (codeword length 7).
module hamming_even_parity_codec #(
   parameter int MAX_CODE_BITS = 63
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [hec_pkg::WORD_W-1:0]         req_payload,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hec_pkg::WORD_W-1:0]         rsp_result_word,
   output logic [hec_pkg::SYN_W-1:0]          rsp_syndrome,
   output logic [1:0]                         rsp_status,

   input  logic                               csr_wr_en,
   input  logic [hec_pkg::LEN_W-1:0]          csr_wr_data
);

   localparam int MaxLim  = (MAX_CODE_BITS > 64) ? 64 : MAX_CODE_BITS;
   // Last data position that fits: the limit itself unless it is a parity slot.
   localparam int SatLen  = ((MaxLim & (MaxLim - 1)) == 0) ? MaxLim - 1 : MaxLim;

   function automatic logic [hec_pkg::CLEN_W-1:0] calc_code_len(
      input logic [hec_pkg::LEN_W-1:0] len
   );
      logic [hec_pkg::CLEN_W-1:0] k;
      logic [hec_pkg::CLEN_W-1:0] n;
      k = (len == '0) ? 7'd1 : {1'b0, len};
      // Parity count r is the smallest with 2**r >= k + r + 1.
      if (k <= 7'd1) begin
         n = k + 7'd2;
      end else if (k <= 7'd4) begin
         n = k + 7'd3;
      end else if (k <= 7'd11) begin
         n = k + 7'd4;
      end else if (k <= 7'd26) begin
         n = k + 7'd5;
      end else begin
         n = k + 7'd6;
      end
      if (k > 7'd57 || n > 7'(SatLen)) begin
         n = 7'(SatLen);
      end
      return n;
   endfunction

   logic [hec_pkg::CLEN_W-1:0] code_len_ff;
   logic [hec_pkg::CLEN_W-1:0] code_len_in;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_op_ff;
   logic [hec_pkg::WORD_W-1:0] s1_payload_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   hec_pkg::result_type        rsp_ff;
   hec_pkg::result_type        rsp_in;

   logic                       req_accept;
   logic                       s1_advance;
   logic [hec_pkg::WORD_W-1:0] code_mask;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign code_len_in  = csr_wr_en ? calc_code_len(csr_wr_data) : code_len_ff;
   assign s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   hec_core u_core (
      .operation (s1_op_ff),
      .payload   (s1_payload_ff),
      .code_len  (code_len_ff),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         code_len_ff  <= calc_code_len(6'd4);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         code_len_ff  <= code_len_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff      <= req_operation;
         s1_payload_ff <= req_payload;
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_ff.word;
   assign rsp_syndrome    = rsp_ff.syndrome;
   assign rsp_status      = rsp_ff.status;

   assign code_mask = (64'd1 << code_len_ff) - 64'd1;

   // A stall toward the requester only happens with both stages holding words.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled while the pipeline has room");

   // Nothing beyond the codeword length ever reaches the response.
   a_word_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_result_word & ~code_mask) == '0))
      else $error("response word has bits beyond the codeword length");

   // A clean status never comes with a nonzero syndrome, and the reverse.
   a_status_syndrome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == hec_pkg::STATUS_OK) == (rsp_syndrome == '0)))
      else $error("status and syndrome disagree");

   // A stalled response word is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("stalled response changed");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamming even parity codec testbench
// Drives encode and decode words through the codec under random idling on
// both channels. A directed table covers the reset length, the extremes and
// the status codes, and random phases then run at several data lengths.
// Every response word is checked field by field against an independent
// prediction of the codec.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_CODE_BITS = 63;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIR_ROWS      = 25;
   localparam int PHASES        = 11;
   localparam int PHASE_WORDS   = 100;

   typedef struct packed {
      logic [hec_pkg::LEN_W-1:0]  len;
      logic                       op;
      logic [hec_pkg::WORD_W-1:0] payload;
      logic                       typed;
      hec_pkg::result_type        want;
   } stim_row_type;

   localparam logic [63:0] ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] CW_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   // Rows with typed set carry a result that is plain from the code itself;
   // the rest are predicted.
   localparam stim_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      '{6'd4,  hec_pkg::OP_ENCODE, 64'h0,    1'b1, '{64'h0,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd4,  hec_pkg::OP_ENCODE, 64'hF,    1'b1, '{64'h7F, 6'd0, hec_pkg::STATUS_OK}},
      '{6'd4,  hec_pkg::OP_ENCODE, ONES,     1'b1, '{64'h7F, 6'd0, hec_pkg::STATUS_OK}},
      '{6'd4,  hec_pkg::OP_DECODE, 64'h7F,   1'b1, '{64'h7F, 6'd0, hec_pkg::STATUS_OK}},
      '{6'd4,  hec_pkg::OP_DECODE, 64'h7E,   1'b1,
                                    '{64'h7F, 6'd1, hec_pkg::STATUS_CORRECTED}},
      '{6'd4,  hec_pkg::OP_DECODE, ONES,     1'b1, '{64'h7F, 6'd0, hec_pkg::STATUS_OK}},
      '{6'd4,  hec_pkg::OP_DECODE, 64'h0,    1'b1, '{64'h0,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd4,  hec_pkg::OP_ENCODE, 64'h5,    1'b0, '{64'h0,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd4,  hec_pkg::OP_DECODE, 64'h3F,   1'b1,
                                    '{64'h7F, 6'd7, hec_pkg::STATUS_CORRECTED}},
      '{6'd0,  hec_pkg::OP_ENCODE, 64'h1,    1'b1, '{64'h7,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd0,  hec_pkg::OP_ENCODE, ONES,     1'b1, '{64'h7,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd0,  hec_pkg::OP_DECODE, 64'h1,    1'b1,
                                    '{64'h0,  6'd1, hec_pkg::STATUS_CORRECTED}},
      '{6'd1,  hec_pkg::OP_DECODE, 64'h6,    1'b1,
                                    '{64'h7,  6'd1, hec_pkg::STATUS_CORRECTED}},
      '{6'd2,  hec_pkg::OP_DECODE, 64'h0A,   1'b1,
                                    '{64'h0A, 6'd6, hec_pkg::STATUS_BEYOND}},
      '{6'd2,  hec_pkg::OP_DECODE, 64'h08,   1'b1,
                                    '{64'h0,  6'd4, hec_pkg::STATUS_CORRECTED}},
      '{6'd2,  hec_pkg::OP_ENCODE, 64'h3,    1'b0, '{64'h0,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd57, hec_pkg::OP_ENCODE, ONES,     1'b1, '{CW_MAX, 6'd0, hec_pkg::STATUS_OK}},
      '{6'd57, hec_pkg::OP_DECODE, ONES,     1'b1, '{CW_MAX, 6'd0, hec_pkg::STATUS_OK}},
      '{6'd57, hec_pkg::OP_DECODE, 64'h3FFF_FFFF_FFFF_FFFF,
                                    1'b1, '{CW_MAX, 6'd63, hec_pkg::STATUS_CORRECTED}},
      '{6'd57, hec_pkg::OP_ENCODE, 64'h0,    1'b1, '{64'h0,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd57, hec_pkg::OP_ENCODE, 64'h0123_4567_89AB_CDEF,
                                    1'b0, '{64'h0,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd63, hec_pkg::OP_ENCODE, ONES,     1'b1, '{CW_MAX, 6'd0, hec_pkg::STATUS_OK}},
      '{6'd63, hec_pkg::OP_DECODE, 64'h8000_0000_0000_0000,
                                    1'b1, '{64'h0,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd63, hec_pkg::OP_DECODE, 64'h5555_5555_5555_5555,
                                    1'b0, '{64'h0,  6'd0, hec_pkg::STATUS_OK}},
      '{6'd11, hec_pkg::OP_DECODE, 64'h0F0F, 1'b0, '{64'h0,  6'd0, hec_pkg::STATUS_OK}}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_operation = hec_pkg::OP_ENCODE;
   logic [hec_pkg::WORD_W-1:0] req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [hec_pkg::WORD_W-1:0] rsp_result_word;
   logic [hec_pkg::SYN_W-1:0]  rsp_syndrome;
   logic [1:0]                 rsp_status;
   logic                       csr_wr_en = 1'b0;
   logic [hec_pkg::LEN_W-1:0]  csr_wr_data = '0;

   hec_pkg::result_type        pending_results [$];
   logic [hec_pkg::LEN_W-1:0]  cur_data_len = 6'd4;
   bit                         calm = 1'b0;
   int                         error_count = 0;
   int                         cycle_count = 0;

   hamming_even_parity_codec #(
      .MAX_CODE_BITS(MAX_CODE_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_word(rsp_result_word),
      .rsp_syndrome   (rsp_syndrome),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   // The codeword ends at the position of the last data bit; lengths past
   // what fits saturate at the top position.
   function automatic int unsigned codeword_len(logic [hec_pkg::LEN_W-1:0] len);
      int unsigned want;
      int unsigned cnt;
      int unsigned last;
      int unsigned p;
      want = (len == 0) ? 1 : len;
      cnt  = 0;
      last = 3;
      for (p = 1; p <= MAX_CODE_BITS && p <= 64; p++) begin
         if ((p & (p - 1)) != 0) begin
            cnt++;
            last = p;
            if (cnt == want) break;
         end
      end
      return last;
   endfunction

   function automatic logic parity_of_group(logic [hec_pkg::WORD_W-1:0] w,
                                            int unsigned j, int unsigned n);
      logic        par;
      int unsigned p;
      par = 1'b0;
      for (p = 1; p <= n; p++) begin
         if ((p & j) != 0) par ^= w[6'(p - 1)];
      end
      return par;
   endfunction

   function automatic hec_pkg::result_type predict_codec(logic op,
                                                         logic [hec_pkg::WORD_W-1:0] pl,
                                                         logic [hec_pkg::LEN_W-1:0] len);
      hec_pkg::result_type        r;
      int unsigned                n;
      int unsigned                p;
      int unsigned                j;
      int unsigned                d;
      int unsigned                syn;
      logic [hec_pkg::WORD_W-1:0] w;
      n   = codeword_len(len);
      w   = '0;
      syn = 0;
      r.status = hec_pkg::STATUS_OK;
      if (op == hec_pkg::OP_ENCODE) begin
         d = 0;
         for (p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) begin
               if (pl[6'(d)]) w[6'(p - 1)] = 1'b1;
               d++;
            end
         end
         for (j = 1; j <= n; j = j << 1) begin
            if (parity_of_group(w, j, n)) w[6'(j - 1)] = 1'b1;
         end
      end else begin
         w = pl & ((64'd1 << n) - 64'd1);
         for (j = 1; j <= n; j = j << 1) begin
            if (parity_of_group(w, j, n)) syn = syn | j;
         end
         if (syn != 0) begin
            if (syn <= n) begin
               w[6'(syn - 1)] = ~w[6'(syn - 1)];
               r.status = hec_pkg::STATUS_CORRECTED;
            end else begin
               r.status = hec_pkg::STATUS_BEYOND;
            end
         end
      end
      r.word     = w;
      r.syndrome = syn[hec_pkg::SYN_W-1:0];
      return r;
   endfunction

   // Called at a clock edge; returns at the edge where the word is taken.
   task automatic send_word(logic op, logic [hec_pkg::WORD_W-1:0] pl,
                            hec_pkg::result_type want);
      if (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 21);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_payload   <= pl;
      do @(posedge clock); while (req_stall);
      pending_results = {pending_results, want};
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_data_len(logic [hec_pkg::LEN_W-1:0] len);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      cur_data_len = len;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time,
                  pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: check each taken word, then decide the next stall.
   always @(posedge clock) begin
      hec_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response word with none expected, actual %h %0d %0d",
                        $time, rsp_result_word, rsp_syndrome, rsp_status);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_word !== want.word) begin
                  $display("%0t: result_word expected %h, actual %h", $time,
                           want.word, rsp_result_word);
                  error_count++;
               end
               if (rsp_syndrome !== want.syndrome) begin
                  $display("%0t: syndrome expected %0d, actual %0d", $time,
                           want.syndrome, rsp_syndrome);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, actual %0d", $time,
                           want.status, rsp_status);
                  error_count++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 21);
      end
   end

   initial begin
      int                         i;
      int                         ph;
      int                         k;
      int unsigned                n;
      logic                       op;
      logic [hec_pkg::WORD_W-1:0] pl;
      logic [hec_pkg::WORD_W-1:0] mask;
      logic [hec_pkg::LEN_W-1:0]  len;
      hec_pkg::result_type        want;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The first rows run at the length left by reset.
      for (i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED_ROWS[i].len != cur_data_len) write_data_len(DIRECTED_ROWS[i].len);
         if (DIRECTED_ROWS[i].typed)
            want = DIRECTED_ROWS[i].want;
         else
            want = predict_codec(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].payload,
                                 cur_data_len);
         send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].payload, want);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: len = 6'd57;
            1: len = 6'd1;
            2: len = 6'd63;
            3: len = 6'd0;
            default: begin
               k = $urandom_range(9);
               if (k == 0)      len = 6'd0;
               else if (k == 1) len = 6'd63;
               else if (k == 2) len = 6'd57;
               else             len = 6'($urandom_range(63));
            end
         endcase
         write_data_len(len);
         calm = (ph == 5);
         n    = codeword_len(cur_data_len);
         mask = (64'd1 << n) - 64'd1;
         for (i = 0; i < PHASE_WORDS; i++) begin
            // Hold off once mid-phase until the pipeline has emptied.
            if (ph == 3 && i == PHASE_WORDS / 2) wait_for_results();
            op = 1'($urandom_range(1));
            pl = {$urandom, $urandom};
            if (op == hec_pkg::OP_DECODE) begin
               k = $urandom_range(9);
               // Mostly valid codewords with zero, one or two flipped bits;
               // the rest is raw noise.
               if (k < 7) begin
                  want = predict_codec(hec_pkg::OP_ENCODE, pl, cur_data_len);
                  pl = want.word;
                  if (k >= 2) pl[6'($urandom_range(n - 1))] ^= 1'b1;
                  if (k == 6) pl[6'($urandom_range(n - 1))] ^= 1'b1;
                  if ($urandom_range(1)) pl = pl | ({$urandom, $urandom} & ~mask);
               end
            end
            send_word(op, pl, predict_codec(op, pl, cur_data_len));
         end
      end
      calm = 1'b0;

      wait_for_results();
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
hdl/hec_pkg.sv
hdl/hec_core.sv
hdl/hamming_even_parity_codec.sv
sim/tb_top.sv
